// ===== hw/rtl/gf2bi_pkg.sv =====
// gf2bi_pkg: shared constants and controller/datapath interface types
// for the GF(2) incremental basis insert block. No dependencies.
package gf2bi_pkg;

  localparam int VEC_W     = 32;               // vector width in bits
  localparam int ROW_SLOTS = 32;               // basis row storage depth
  localparam int IDX_W     = $clog2(ROW_SLOTS); // row address / pivot width
  localparam int RANK_W    = IDX_W + 1;        // holds 0..ROW_SLOTS
  localparam int DIMCFG_W  = 6;                // dim_in_use register width
  localparam int ROW_W     = VEC_W + IDX_W;    // stored word: {pivot, row}

  localparam logic [DIMCFG_W-1:0] DIM_RESET = DIMCFG_W'(32);

  // controller -> datapath
  typedef struct packed {
    logic load;    // take new vector, start first row read
    logic step;    // fold in the row whose read data is present
    logic finish;  // mask, pivot search, write-back, result capture
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rank_zero;  // no stored rows
    logic last_row;   // current row is the last stored one
  } status_t;

endpackage

// ===== hw/rtl/gf2bi_ram.sv =====
// gf2bi_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module gf2bi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/gf2bi_ctrl.sv =====
// gf2bi_ctrl: sequencing state machine for one insert operation.
// Depends on gf2bi_pkg.
module gf2bi_ctrl import gf2bi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ELIM   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = status.rank_zero ? ST_FINISH : ST_ELIM;
        end
      end
      ST_ELIM: begin
        cmd.step = 1'b1;
        if (status.last_row) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== hw/rtl/gf2bi_dp.sv =====
// gf2bi_dp: vector register, row RAM, rank counter, pivot search and
// result registers. Depends on gf2bi_pkg and gf2bi_ram.
module gf2bi_dp import gf2bi_pkg::*; #(
  parameter int DIM = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [VEC_W-1:0]    image_bits,
  input  logic                cfg_we,
  input  logic [DIMCFG_W-1:0] cfg_wdata,
  output logic                done,
  output logic                independent,
  output logic [IDX_W-1:0]    pivot_column,
  output logic [RANK_W-1:0]   new_rank,
  output logic [VEC_W-1:0]    reduced_bits
);

  // active dimension saturates at the smaller of DIM and the vector width
  localparam int ACT_LIM = (DIM < VEC_W) ? DIM : VEC_W;
  localparam logic [DIMCFG_W-1:0] LIM_CODE = DIMCFG_W'(ACT_LIM);
  localparam logic [RANK_W-1:0]   FULL     = RANK_W'(ROW_SLOTS);

  logic [DIMCFG_W-1:0] dim_reg;
  logic [DIMCFG_W-1:0] dim_eff;
  logic [VEC_W-1:0]    mask;
  logic [VEC_W-1:0]    vec;
  logic [IDX_W-1:0]    rd_cnt;
  logic [RANK_W-1:0]   rank;
  logic [RANK_W-1:0]   rank_next;

  logic [IDX_W-1:0]    raddr;
  logic [ROW_W-1:0]    rdata;
  logic [VEC_W-1:0]    row_bits;
  logic [IDX_W-1:0]    row_piv;

  logic [VEC_W-1:0]    vec_m;
  logic [IDX_W-1:0]    piv;
  logic                indep;
  logic                wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_reg <= DIM_RESET;
    end else if (cfg_we) begin
      dim_reg <= cfg_wdata;
    end
  end

  always_comb begin
    dim_eff = (dim_reg > LIM_CODE) ? LIM_CODE : dim_reg;
    if (dim_eff >= DIMCFG_W'(VEC_W)) begin
      mask = '1;
    end else begin
      mask = ~({VEC_W{1'b1}} << dim_eff);
    end
  end

  // read of row rd_cnt lands the cycle after its address is issued
  assign raddr    = cmd.load ? '0 : rd_cnt + IDX_W'(1);
  assign row_bits = rdata[VEC_W-1:0];
  assign row_piv  = rdata[ROW_W-1:VEC_W];

  gf2bi_ram #(
    .WIDTH(ROW_W),
    .DEPTH(ROW_SLOTS)
  ) u_rows (
    .clk  (clk),
    .we   (wr_en),
    .waddr(rank[IDX_W-1:0]),
    .wdata({piv, vec_m}),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vec    <= image_bits & mask;
      rd_cnt <= '0;
    end else if (cmd.step) begin
      rd_cnt <= rd_cnt + IDX_W'(1);
      if (vec[row_piv]) begin
        vec <= vec ^ row_bits;
      end
    end
  end

  assign status.rank_zero = (rank == '0);
  assign status.last_row  = ((RANK_W'(rd_cnt) + RANK_W'(1)) == rank);

  // lowest set bit of the masked vector
  always_comb begin
    vec_m = vec & mask;
    piv   = '0;
    for (int i = VEC_W - 1; i >= 0; i--) begin
      if (vec_m[i]) begin
        piv = IDX_W'(i);
      end
    end
    indep     = (vec_m != '0) && (rank != FULL);
    wr_en     = cmd.finish && indep;
    rank_next = indep ? rank + RANK_W'(1) : rank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (wr_en) begin
        rank <= rank_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      independent  <= indep;
      pivot_column <= indep ? piv : '0;
      new_rank     <= rank_next;
      reduced_bits <= vec_m;
    end
  end

endmodule

// ===== hw/rtl/gf2_incremental_basis_insert.sv =====
// gf2_incremental_basis_insert: incremental GF(2) row-echelon basis builder.
// Steps: a load step, one step per stored row read from the row RAM, then a
//   finish step; the done strobe is registered from the finish step.
// A new start is taken only while busy is low; the single read port of the
//   row RAM is visited one row per cycle.
// Reset (rst, sync, active high) clears rank and sets dim_in_use to 32;
//   row RAM is not cleared. done cannot be stalled by the receiver.
module gf2_incremental_basis_insert import gf2bi_pkg::*; #(
  parameter int DIM = 32
) (
  input  logic                clk,
  input  logic                rst,
  // command side: transfer when start && !busy
  input  logic                start,
  output logic                busy,
  input  logic [VEC_W-1:0]    image_bits,
  // dim_in_use register write
  input  logic                cfg_we,
  input  logic [DIMCFG_W-1:0] cfg_wdata,
  // result side: valid for the single cycle done is high
  output logic                done,
  output logic                independent,
  output logic [IDX_W-1:0]    pivot_column,
  output logic [RANK_W-1:0]   new_rank,
  output logic [VEC_W-1:0]    reduced_bits
);

  cmd_t    cmd;     // load / step / finish from the sequencer
  status_t status;  // rank empty, last row reached

  // Sequencer: idle -> eliminate (one row per cycle) -> finish -> idle.
  // Rank zero skips straight to finish.
  gf2bi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath: the vector is masked on load, XORed with each stored row whose
  // pivot bit is set, masked again; if nonzero with rank below ROW_SLOTS, the
  // lowest set bit becomes the pivot of a new row written at address rank.
  gf2bi_dp #(
    .DIM(DIM)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .image_bits  (image_bits),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .done        (done),
    .independent (independent),
    .pivot_column(pivot_column),
    .new_rank    (new_rank),
    .reduced_bits(reduced_bits)
  );

endmodule
